// ----- hdl/assert_macros.svh -----
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- hdl/cgi_pkg.sv -----
`default_nettype none
package cgi_pkg;

   localparam int MAX_STOPS     = 7;
   localparam int POSITION_BITS = 16;
   localparam int FRAC_BITS     = 16;
   localparam int DIV_STEP      = 4;
   localparam int DIV_STAGES    = FRAC_BITS / DIV_STEP;
   localparam int LATENCY       = DIV_STAGES + 3;

   localparam int STOP_W     = 40;
   localparam int POS_LSB    = 24;
   localparam int CHAN_W     = 8;
   localparam int NUM_CHANS  = 3;
   localparam int COLOR_W    = CHAN_W * NUM_CHANS;
   localparam int PROD_W     = CHAN_W + FRAC_BITS + 1;
   localparam int COUNT_W    = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int STOP_IDX_W = $clog2(MAX_STOPS);

   localparam logic [CSR_IDX_W-1:0] CSR_STOP_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_BASE  = 3'd1;

   localparam logic [FRAC_BITS:0] FRAC_ONE  = (FRAC_BITS + 1)'(1) << FRAC_BITS;
   localparam logic [PROD_W:0]    FRAC_HALF = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

   typedef logic [POSITION_BITS-1:0] pos_type;
   typedef logic [COLOR_W-1:0]       color_type;
   typedef logic [STOP_W-1:0]        stop_type;

   typedef struct packed {
      logic                 interp;
      logic                 nz;
      pos_type              rem;
      pos_type              den;
      logic [FRAC_BITS-1:0] quo;
      color_type            c_from;
      color_type            c_to;
   } div_type;

   function automatic pos_type stop_pos(stop_type s);
      return POSITION_BITS'(s >> POS_LSB);
   endfunction

   function automatic color_type stop_color(stop_type s);
      return s[COLOR_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ----- hdl/color_gradient_interpolator.sv -----
// Piecewise-linear color gradient: maps a position to an RGB color from up to
// seven sorted stops.
// Input: a position is taken at each clock edge where start is high and busy
// is low. busy is high only in the cycle after reset, so one position can be
// taken every cycle.
// Output: each position yields one beat, shown for one cycle with rsp_strobe
// high, in input order. The receiver cannot stall; beats are never held.
// Pipeline: each position passes interval compare, four divider stages of four
// quotient bits each with the interval select in the first, channel products,
// and round with the output register, in that order.
// The fraction divider is pipelined, so throughput is one position per cycle.
// Config: csr_index 0 is the stop count, 1..7 are the stops (position in
// bits 39:24, red 23:16, green 15:8, blue 7:0). csr_ready is high except in
// the cycle after reset. Write only while no beat is in flight.
// Reset: synchronous, clears the stop count, stops and all valid bits; with
// no stops the block returns black with rsp_color_valid low.
`default_nettype none
`include "assert_macros.svh"
module color_gradient_interpolator (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output      logic                                busy,
   input  wire logic [cgi_pkg::POSITION_BITS-1:0]   req_position,
   output      logic                                rsp_strobe,
   output      logic [cgi_pkg::CHAN_W-1:0]          rsp_red,
   output      logic [cgi_pkg::CHAN_W-1:0]          rsp_green,
   output      logic [cgi_pkg::CHAN_W-1:0]          rsp_blue,
   output      logic                                rsp_color_valid,
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [cgi_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [cgi_pkg::STOP_W-1:0]          csr_wdata
);

   logic                             busy_ff;
   logic                             accept;
   logic [cgi_pkg::COUNT_W-1:0]      stop_count_ff;
   cgi_pkg::stop_type                stop_ff [cgi_pkg::MAX_STOPS];

   logic [cgi_pkg::COUNT_W-1:0]      n_eff;
   logic [cgi_pkg::MAX_STOPS-2:0]    match_in;
   logic [cgi_pkg::STOP_IDX_W-1:0]   last_in;
   logic                             ge_last_in;

   logic                             s1_valid_ff;
   cgi_pkg::pos_type                 s1_pos_ff;
   logic [cgi_pkg::MAX_STOPS-2:0]    s1_match_ff;
   logic [cgi_pkg::STOP_IDX_W-1:0]   s1_last_ff;
   logic                             s1_ge_last_ff;
   logic                             s1_nz_ff;

   logic [cgi_pkg::STOP_IDX_W-1:0]   sel;
   logic                             hit;
   cgi_pkg::stop_type                stop_from;
   cgi_pkg::stop_type                stop_to;
   cgi_pkg::div_type                 div_first;

   logic                             div_valid_ff [cgi_pkg::DIV_STAGES];
   cgi_pkg::div_type                 div_ff       [cgi_pkg::DIV_STAGES];

   logic [cgi_pkg::FRAC_BITS-1:0]    frac;
   logic [cgi_pkg::FRAC_BITS:0]      wfrom;
   logic                             mul_valid_ff;
   logic                             mul_nz_ff;
   logic [cgi_pkg::PROD_W-1:0]       mul_a_ff [cgi_pkg::NUM_CHANS];
   logic [cgi_pkg::PROD_W-1:0]       mul_b_ff [cgi_pkg::NUM_CHANS];

   logic [cgi_pkg::PROD_W:0]         sum      [cgi_pkg::NUM_CHANS];
   logic [cgi_pkg::CHAN_W-1:0]       chan_out [cgi_pkg::NUM_CHANS];
   logic                             out_valid_ff;
   logic                             out_nz_ff;
   logic [cgi_pkg::CHAN_W-1:0]       out_ff   [cgi_pkg::NUM_CHANS];

   assign busy      = busy_ff;
   assign csr_ready = !busy_ff;
   assign accept    = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         stop_count_ff <= '0;
         for (int i = 0; i < cgi_pkg::MAX_STOPS; i++) begin
            stop_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         if (csr_index == cgi_pkg::CSR_STOP_COUNT) begin
            stop_count_ff <= csr_wdata[cgi_pkg::COUNT_W-1:0];
         end else begin
            for (int i = 0; i < cgi_pkg::MAX_STOPS; i++) begin
               if (csr_index == cgi_pkg::CSR_STOP_BASE + cgi_pkg::CSR_IDX_W'(i)) begin
                  stop_ff[i] <= csr_wdata;
               end
            end
         end
      end
   end

   // stage 1: interval compares
   always_comb begin
      n_eff = (stop_count_ff > cgi_pkg::COUNT_W'(cgi_pkg::MAX_STOPS))
            ? cgi_pkg::COUNT_W'(cgi_pkg::MAX_STOPS) : stop_count_ff;
      for (int i = 0; i < cgi_pkg::MAX_STOPS - 1; i++) begin
         match_in[i] = (cgi_pkg::COUNT_W'(i + 1) < n_eff)
                    && (req_position >= cgi_pkg::stop_pos(stop_ff[i]))
                    && (req_position <  cgi_pkg::stop_pos(stop_ff[i + 1]));
      end
      last_in    = cgi_pkg::STOP_IDX_W'(n_eff - cgi_pkg::COUNT_W'(1));
      ge_last_in = req_position >= cgi_pkg::stop_pos(stop_ff[last_in]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_pos_ff     <= req_position;
      s1_match_ff   <= match_in;
      s1_last_ff    <= last_in;
      s1_ge_last_ff <= ge_last_in;
      s1_nz_ff      <= n_eff != '0;
   end

   // stage 2: pick the first matching pair, form numerator and denominator
   always_comb begin
      sel = '0;
      hit = 1'b0;
      for (int i = cgi_pkg::MAX_STOPS - 2; i >= 0; i--) begin
         if (s1_match_ff[i]) begin
            sel = cgi_pkg::STOP_IDX_W'(i);
            hit = 1'b1;
         end
      end
      stop_from = stop_ff[sel];
      stop_to   = stop_ff[sel + cgi_pkg::STOP_IDX_W'(1)];

      div_first.interp = hit;
      div_first.nz     = s1_nz_ff;
      div_first.rem    = hit ? s1_pos_ff - cgi_pkg::stop_pos(stop_from) : '0;
      div_first.den    = cgi_pkg::stop_pos(stop_to) - cgi_pkg::stop_pos(stop_from);
      div_first.quo    = '0;
      div_first.c_to   = cgi_pkg::stop_color(stop_to);
      priority if (!s1_nz_ff) begin
         div_first.c_from = '0;
      end else if (hit) begin
         div_first.c_from = cgi_pkg::stop_color(stop_from);
      end else if (s1_ge_last_ff) begin
         div_first.c_from = cgi_pkg::stop_color(stop_ff[s1_last_ff]);
      end else begin
         div_first.c_from = cgi_pkg::stop_color(stop_ff[0]);
      end
   end

   // fraction divider: restoring, DIV_STEP quotient bits per stage
   for (genvar k = 0; k < cgi_pkg::DIV_STAGES; k++) begin : g_div
      cgi_pkg::div_type src;
      cgi_pkg::div_type div_in;
      logic             src_valid;

      if (k == 0) begin : g_head
         assign src       = div_first;
         assign src_valid = s1_valid_ff;
      end else begin : g_body
         assign src       = div_ff[k - 1];
         assign src_valid = div_valid_ff[k - 1];
      end

      always_comb begin
         logic [cgi_pkg::POSITION_BITS:0] trial;
         div_in = src;
         for (int j = 0; j < cgi_pkg::DIV_STEP; j++) begin
            trial = {div_in.rem, 1'b0};
            if (trial >= {1'b0, div_in.den}) begin
               div_in.rem = cgi_pkg::POSITION_BITS'(trial - {1'b0, div_in.den});
               div_in.quo = {div_in.quo[cgi_pkg::FRAC_BITS-2:0], 1'b1};
            end else begin
               div_in.rem = cgi_pkg::POSITION_BITS'(trial);
               div_in.quo = {div_in.quo[cgi_pkg::FRAC_BITS-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[k] <= 1'b0;
         end else begin
            div_valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         div_ff[k] <= div_in;
      end
   end

   // channel products
   always_comb begin
      frac  = div_ff[cgi_pkg::DIV_STAGES-1].interp
            ? div_ff[cgi_pkg::DIV_STAGES-1].quo : '0;
      wfrom = cgi_pkg::FRAC_ONE - {1'b0, frac};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= div_valid_ff[cgi_pkg::DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      mul_nz_ff <= div_ff[cgi_pkg::DIV_STAGES-1].nz;
      for (int ch = 0; ch < cgi_pkg::NUM_CHANS; ch++) begin
         mul_a_ff[ch] <= cgi_pkg::PROD_W'(
            div_ff[cgi_pkg::DIV_STAGES-1].c_from[ch*cgi_pkg::CHAN_W +: cgi_pkg::CHAN_W])
            * cgi_pkg::PROD_W'(wfrom);
         mul_b_ff[ch] <= cgi_pkg::PROD_W'(
            div_ff[cgi_pkg::DIV_STAGES-1].c_to[ch*cgi_pkg::CHAN_W +: cgi_pkg::CHAN_W])
            * cgi_pkg::PROD_W'(frac);
      end
   end

   // round half up and output register
   always_comb begin
      for (int ch = 0; ch < cgi_pkg::NUM_CHANS; ch++) begin
         sum[ch] = {1'b0, mul_a_ff[ch]} + {1'b0, mul_b_ff[ch]} + cgi_pkg::FRAC_HALF;
         chan_out[ch] = sum[ch][cgi_pkg::FRAC_BITS +: cgi_pkg::CHAN_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_nz_ff <= mul_nz_ff;
      for (int ch = 0; ch < cgi_pkg::NUM_CHANS; ch++) begin
         out_ff[ch] <= chan_out[ch];
      end
   end

   assign rsp_strobe      = out_valid_ff;
   assign rsp_color_valid = out_nz_ff;
   assign rsp_red         = out_ff[2];
   assign rsp_green       = out_ff[1];
   assign rsp_blue        = out_ff[0];

   `ASSERT_IMPLIES(a_beat_follows_req, clock, reset, rsp_strobe,
                   $past(accept, cgi_pkg::LATENCY))
   `ASSERT_IMPLIES(a_no_stops_black, clock, reset, rsp_strobe && !rsp_color_valid,
                   rsp_red == '0 && rsp_green == '0 && rsp_blue == '0)
   `ASSERT_NEXT(a_count_write, clock, reset,
                csr_valid && csr_ready && csr_index == cgi_pkg::CSR_STOP_COUNT,
                stop_count_ff == $past(csr_wdata[cgi_pkg::COUNT_W-1:0]))

endmodule
`default_nettype wire

// ----- sim/tb_color_gradient_interpolator.sv -----
module tb_color_gradient_interpolator;
   timeunit 1ns;
   timeprecision 1ps;

   import cgi_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 70;
   localparam int RANDOM_PHASES  = 12;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              color_valid;
   } color_beat_type;

   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 start        = 1'b0;
   logic                 busy;
   pos_type              req_position = '0;
   logic                 rsp_strobe;
   logic [CHAN_W-1:0]    rsp_red;
   logic [CHAN_W-1:0]    rsp_green;
   logic [CHAN_W-1:0]    rsp_blue;
   logic                 rsp_color_valid;
   logic                 csr_valid    = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index    = '0;
   stop_type             csr_wdata    = '0;

   // shadow of the block's registers
   logic [COUNT_W-1:0]   stop_count_cfg = '0;
   stop_type             stop_table [MAX_STOPS];

   pos_type              pending_positions [$];
   color_beat_type       expected_colors [$];

   int                   burst_left     = 1;
   int                   gap_left       = 0;
   int                   stall_cycles   = 0;
   int                   failure_count  = 0;
   int                   positions_sent = 0;
   int                   colors_checked = 0;
   int                   table_count    = 0;

   color_gradient_interpolator DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_position    (req_position),
      .rsp_strobe      (rsp_strobe),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_color_valid (rsp_color_valid),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [CHAN_W-1:0] mix_channel(input longint unsigned a,
                                                     input longint unsigned b,
                                                     input longint unsigned frac);
      return CHAN_W'((a * ((64'd1 << FRAC_BITS) - frac) + b * frac
                      + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
   endfunction

   function automatic color_beat_type gradient_color(input pos_type position);
      longint unsigned pv, lo_pos, hi_pos, frac;
      stop_type        chosen;
      color_beat_type  beat;
      int              n;
      bit              matched;
      beat    = '0;
      n       = int'(stop_count_cfg);
      pv      = position;
      matched = 1'b0;
      if (n == 0) begin
         return beat;
      end
      chosen = stop_table[0];
      for (int k = 0; k + 1 < n && !matched; k++) begin
         lo_pos = stop_table[k][POS_LSB +: POSITION_BITS];
         hi_pos = stop_table[k+1][POS_LSB +: POSITION_BITS];
         if (pv >= lo_pos && pv < hi_pos) begin
            frac       = ((pv - lo_pos) << FRAC_BITS) / (hi_pos - lo_pos);
            beat.red   = mix_channel(stop_table[k][2*CHAN_W +: CHAN_W],
                                     stop_table[k+1][2*CHAN_W +: CHAN_W], frac);
            beat.green = mix_channel(stop_table[k][CHAN_W +: CHAN_W],
                                     stop_table[k+1][CHAN_W +: CHAN_W], frac);
            beat.blue  = mix_channel(stop_table[k][0 +: CHAN_W],
                                     stop_table[k+1][0 +: CHAN_W], frac);
            matched    = 1'b1;
         end
      end
      if (!matched) begin
         if (n > 1 && pv >= stop_table[n-1][POS_LSB +: POSITION_BITS]) begin
            chosen = stop_table[n-1];
         end
         beat.red   = chosen[2*CHAN_W +: CHAN_W];
         beat.green = chosen[CHAN_W +: CHAN_W];
         beat.blue  = chosen[0 +: CHAN_W];
      end
      beat.color_valid = 1'b1;
      return beat;
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input stop_type data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == CSR_STOP_COUNT) begin
         stop_count_cfg = data[COUNT_W-1:0];
      end else begin
         stop_table[int'(index - CSR_STOP_BASE)] = data;
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_positions.size() != 0 || start || expected_colors.size() != 0);
      repeat (LATENCY + 2) @(negedge clock);
   endtask

   // driver: bursts of beats separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (gap_left != 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_positions.size() != 0) begin
            start        <= 1'b1;
            req_position <= pending_positions.pop_front();
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 48);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left--;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: predict on accepted beats, check result beats in order
   always @(posedge clock) begin : monitor
      color_beat_type got, want;
      if (!reset) begin
         if (rsp_strobe) begin
            got = '{rsp_red, rsp_green, rsp_blue, rsp_color_valid};
            if (expected_colors.size() == 0) begin
               failure_count++;
               if (failure_count <= 10) begin
                  $display("%0t: result beat with none expected: r=%02h g=%02h b=%02h v=%0b",
                           $realtime, got.red, got.green, got.blue, got.color_valid);
               end
            end else begin
               want = expected_colors.pop_front();
               colors_checked++;
               if (got !== want) begin
                  failure_count++;
                  if (failure_count <= 10) begin
                     $display("%0t: mismatch: expected r=%02h g=%02h b=%02h v=%0b, ",
                              $realtime, want.red, want.green, want.blue,
                              want.color_valid,
                              "got r=%02h g=%02h b=%02h v=%0b",
                              got.red, got.green, got.blue, got.color_valid);
                  end
               end
            end
         end
         if (start && !busy) begin
            expected_colors.push_back(gradient_color(req_position));
            positions_sent++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      pos_type     ramp_points [12] = '{16'h0000, 16'h0FFF, 16'h1000, 16'h1800, 16'h1FFF,
                                        16'h2000, 16'h2001, 16'h5000, 16'h7FFF, 16'hA000,
                                        16'hFFFE, 16'hFFFF};
      stop_type    ramp_stops [MAX_STOPS] = '{{16'h1000, 24'h000000}, {16'h2000, 24'hFFFFFF},
                                              {16'h2000, 24'h00FF00}, {16'h2001, 24'hFF0000},
                                              {16'h8000, 24'h0000FF}, {16'hC000, 24'h80FF01},
                                              {16'hFFFF, 24'hFF00FF}};
      pos_type     stop_at [MAX_STOPS];
      pos_type     tmp;
      logic [23:0] color;
      int          ph, k, j, mode, n_stops, pick;

      foreach (stop_table[i]) stop_table[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // no stops after reset: black, not valid
      pending_positions.push_back(16'h0000);
      pending_positions.push_back(16'hFFFF);
      pending_positions.push_back(16'h8000);
      wait_drained();
      table_count++;

      // single stop
      write_csr(CSR_STOP_COUNT, stop_type'(1));
      write_csr(CSR_STOP_BASE, {16'h8000, 24'h123456});
      pending_positions.push_back(16'h0000);
      pending_positions.push_back(16'h8000);
      pending_positions.push_back(16'hFFFF);
      wait_drained();
      table_count++;

      // full table: below first, empty interval, span of one, last stop at top
      write_csr(CSR_STOP_COUNT, stop_type'(MAX_STOPS));
      for (k = 0; k < MAX_STOPS; k++) begin
         write_csr(CSR_STOP_BASE + CSR_IDX_W'(k), ramp_stops[k]);
      end
      foreach (ramp_points[i]) pending_positions.push_back(ramp_points[i]);
      wait_drained();
      table_count++;

      // unsorted stops
      write_csr(CSR_STOP_COUNT, stop_type'(3));
      write_csr(CSR_STOP_BASE,                   {16'h5000, 24'hAAAAAA});
      write_csr(CSR_STOP_BASE + CSR_IDX_W'(1), {16'h3000, 24'h555555});
      write_csr(CSR_STOP_BASE + CSR_IDX_W'(2), {16'h9000, 24'hFFFFFF});
      pending_positions.push_back(16'h1000);
      pending_positions.push_back(16'h4000);
      pending_positions.push_back(16'hA000);
      wait_drained();
      table_count++;

      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: n_stops = MAX_STOPS;
            1: n_stops = 0;
            2: n_stops = 1;
            3: n_stops = 2;
            default: n_stops = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, MAX_STOPS);
         endcase
         mode = $urandom_range(0, 9);
         if (mode == 1) begin
            stop_at[0] = pos_type'($urandom_range(0, 65535 - 30));
            for (k = 1; k < MAX_STOPS; k++) begin
               stop_at[k] = stop_at[k-1] + pos_type'($urandom_range(0, 4));
            end
         end else begin
            for (k = 0; k < MAX_STOPS; k++) stop_at[k] = pos_type'($urandom);
            if (mode != 0) begin
               for (k = 0; k < MAX_STOPS; k++) begin
                  for (j = 0; j < MAX_STOPS - 1 - k; j++) begin
                     if (stop_at[j] > stop_at[j+1]) begin
                        tmp          = stop_at[j];
                        stop_at[j]   = stop_at[j+1];
                        stop_at[j+1] = tmp;
                     end
                  end
               end
               if ($urandom_range(0, 2) == 0 && n_stops >= 2) begin
                  stop_at[0]         = '0;
                  stop_at[n_stops-1] = '1;
               end
            end
         end
         write_csr(CSR_STOP_COUNT, stop_type'($urandom) & ~stop_type'(7) | stop_type'(n_stops));
         for (k = 0; k < MAX_STOPS; k++) begin
            color = 24'($urandom);
            if ($urandom_range(0, 3) == 0) begin
               color = {$urandom_range(0, 1) ? 8'hFF : 8'h00,
                        $urandom_range(0, 1) ? 8'hFF : 8'h00,
                        $urandom_range(0, 1) ? 8'hFF : 8'h00};
            end
            write_csr(CSR_STOP_BASE + CSR_IDX_W'(k), {stop_at[k], color});
         end
         for (k = 0; k < PHASE_ITEMS; k++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               tmp = $urandom_range(0, 1) ? '1 : '0;
            end else if (pick <= 3) begin
               j   = $urandom_range(0, MAX_STOPS - 1);
               tmp = stop_table[j][POS_LSB +: POSITION_BITS]
                     + pos_type'($urandom_range(0, 4)) - pos_type'(2);
            end else begin
               tmp = pos_type'($urandom);
            end
            pending_positions.push_back(tmp);
         end
         wait_drained();
         table_count++;
      end

      failure_count += expected_colors.size();
      $display("Run covered %0d positions over %0d stop tables; %0d colors checked.",
               positions_sent, table_count, colors_checked);
      if (failure_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d failures", failure_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
